[hdl/tola_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tola_pkg;

  // Field widths fixed by the message format
  localparam int unsigned ID_W    = 4;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned QCNT_W  = 4;

  // Default number of queue slots (one per client)
  localparam int unsigned MAX_CLIENTS_DEFAULT = 8;

  // Command codes on the request channel
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Operation class decided by the front end
  typedef enum logic [1:0] {
    OP_IGNORE  = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2
  } op_kind_t;

  // One classified operation waiting for the back end
  typedef struct packed {
    op_kind_t             kind;
    logic [ID_W-1:0]      client_id;
    logic [STAMP_W-1:0]   stamp;
  } op_t;

  // One queue slot
  typedef struct packed {
    logic [ID_W-1:0]      client_id;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic                 grant_valid;
    logic [ID_W-1:0]      grant_client;
    logic                 locked;
    logic [ID_W-1:0]      holder;
    logic [QCNT_W-1:0]    queue_count;
    logic                 overflow;
    logic                 unknown_release;
  } result_t;

  // Handshake between the operation queue and the back end
  typedef struct packed {
    logic                 empty;
    op_t                  head;
  } opq_status_t;

endpackage

`default_nettype wire

[hdl/tola_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tola_req_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [tola_pkg::ID_W-1:0]        client_id;
  logic [tola_pkg::STAMP_W-1:0]     stamp;

  modport source (output valid, output cmd, output client_id, output stamp, input ready);
  modport sink   (input valid, input cmd, input client_id, input stamp, output ready);
endinterface

`default_nettype wire

[hdl/tola_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tola_res_if;
  logic                             valid;
  logic                             ready;
  logic                             grant_valid;
  logic [tola_pkg::ID_W-1:0]        grant_client;
  logic                             locked;
  logic [tola_pkg::ID_W-1:0]        holder;
  logic [tola_pkg::QCNT_W-1:0]      queue_count;
  logic                             overflow;
  logic                             unknown_release;

  modport source (output valid, output grant_valid, output grant_client, output locked,
                  output holder, output queue_count, output overflow,
                  output unknown_release, input ready);
  modport sink   (input valid, input grant_valid, input grant_client, input locked,
                  input holder, input queue_count, input overflow,
                  input unknown_release, output ready);
endinterface

`default_nettype wire

[hdl/timestamp_ordered_lock_arbiter.sv]
// Timestamp-ordered lock arbiter.
// req channel: one beat per lock message (cmd, client_id, stamp). cmd request
//   queues the client behind the holder in stamp order; cmd release by the
//   holder frees the lock or passes it to the next waiter, else withdraws the
//   client's first waiting entry. Ids outside 1..MAX_CLIENTS are ignored.
// res channel: exactly one beat per accepted message with the grant, lock
//   state, holder, queue fill and the overflow / unknown-release flags.
// A front end classifies each beat into a two-deep operation queue; the back
//   end owns the queue memory and works one operation at a time.
// A message that needs no memory walk passes from the accepted req beat
//   through the operation queue and the back end to the output register;
//   an insert or removal deep in the queue first walks the queue memory
//   one slot per cycle (one write port, one registered read port).
// The back end pops a new message only once the last result is published.
// Reset empties the queue and frees the lock; slot contents are not cleared.
// A stalled receiver holds the result in the output register; the back end
//   then waits, and req.ready drops once the operation queue is full.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_ordered_lock_arbiter #(
  parameter int unsigned MAX_CLIENTS = tola_pkg::MAX_CLIENTS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tola_req_if.sink   req,
  tola_res_if.source res
);

  logic                  q_full;
  logic                  q_push;
  tola_pkg::op_t         q_push_data;
  logic                  q_pop;
  tola_pkg::opq_status_t q_status;

  tola_front #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  tola_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .status    (q_status)
  );

  tola_back #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_pop    (q_pop),
    .res      (res)
  );

  // A grant always leaves the lock held
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.grant_valid) |-> res.locked)
    else $error("grant reported with lock free");

  // A free lock means an empty queue and no holder
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.locked) |-> ((res.holder == '0) && (res.queue_count == '0)))
    else $error("free lock with holder or queued entries");

  // One message cannot both overflow and name an absent client
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.overflow && res.unknown_release))
    else $error("overflow and unknown release together");

  // No result right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

[hdl/tola_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module tola_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tola_pkg::op_t         push_data,
  output      logic                  full,
  input  wire logic                  pop,
  output      tola_pkg::opq_status_t status
);

  tola_pkg::op_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;

  // Track occupancy
  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt_next;
    end
  end

  // Store the incoming operation
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign full         = (cnt == 2'd2);
  assign status.empty = (cnt == 2'd0);
  assign status.head  = slots[rd_ptr];

endmodule

`default_nettype wire

[hdl/tola_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tola_front #(
  parameter int unsigned MAX_CLIENTS = tola_pkg::MAX_CLIENTS_DEFAULT
) (
  tola_req_if.sink             req,
  input  wire logic            q_full,
  output      logic            push,
  output      tola_pkg::op_t   push_data
);

  logic id_ok;

  // Accept a beat whenever the operation queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // Classify: ids outside 1..MAX_CLIENTS become OP_IGNORE and have no effect
  assign id_ok = (req.client_id != '0) && (32'(req.client_id) <= 32'(MAX_CLIENTS));

  always_comb begin
    push_data.client_id = req.client_id;
    push_data.stamp     = req.stamp;
    if (!id_ok) begin
      push_data.kind = tola_pkg::OP_IGNORE;
    end else if (req.cmd == tola_pkg::CMD_RELEASE) begin
      push_data.kind = tola_pkg::OP_RELEASE;
    end else begin
      push_data.kind = tola_pkg::OP_REQUEST;
    end
  end

endmodule

`default_nettype wire

[hdl/tola_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tola_back #(
  parameter int unsigned MAX_CLIENTS = tola_pkg::MAX_CLIENTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tola_pkg::opq_status_t q_status,
  output      logic                  q_pop,
  tola_res_if.source                 res
);

  localparam int unsigned AW        = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned CW        = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned MEM_DEPTH = 1 << AW;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS     = 8'b0000_0100,
    S_INS_PUT = 8'b0000_1000,
    S_SRCH_RD = 8'b0001_0000,
    S_SRCH    = 8'b0010_0000,
    S_SHF_RD  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  // S_SHF reuses the search read pipeline, so it is a separate one-hot bit group
  typedef enum logic [1:0] {
    SHF_OFF = 2'b01,
    SHF_ON  = 2'b10
  } shf_t;

  // Queue storage
  tola_pkg::entry_t mem [MEM_DEPTH];
  tola_pkg::entry_t rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  tola_pkg::entry_t mem_wdata;
  logic [AW-1:0]    mem_raddr;

  // Control state
  state_t               state, state_next;
  shf_t                 shf, shf_next;
  logic [CW-1:0]        count, count_next;
  logic                 locked, locked_next;
  logic [tola_pkg::ID_W-1:0] holder, holder_next;

  // Operation in progress
  tola_pkg::op_t        op, op_next;
  logic [AW-1:0]        idx, idx_next;
  logic                 hrel, hrel_next;
  logic                 gvalid, gvalid_next;
  logic [tola_pkg::ID_W-1:0] gclient, gclient_next;
  logic                 ovf, ovf_next;
  logic                 unk, unk_next;

  // Output register
  logic                 res_valid, res_valid_next;
  tola_pkg::result_t    res_data, res_data_next;

  logic [CW-1:0]        cnt_m1;
  logic                 idx_last;
  logic                 idx_p1_last;
  logic [CW+3:0]        cnt_wide;
  tola_pkg::entry_t     new_entry;
  tola_pkg::entry_t     head_entry;

  assign cnt_m1      = count - CW'(1);
  assign idx_last    = (CW'(idx) == cnt_m1);
  assign idx_p1_last = ((CW'(idx) + CW'(1)) == cnt_m1);
  assign cnt_wide    = {4'd0, count};
  assign new_entry   = '{client_id: op.client_id, stamp: op.stamp};
  assign head_entry  = '{client_id: q_status.head.client_id, stamp: q_status.head.stamp};

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    shf_next       = shf;
    count_next     = count;
    locked_next    = locked;
    holder_next    = holder;
    op_next        = op;
    idx_next       = idx;
    hrel_next      = hrel;
    gvalid_next    = gvalid;
    gclient_next   = gclient;
    ovf_next       = ovf;
    unk_next       = unk;
    res_valid_next = res_valid && !res.ready;
    res_data_next  = res_data;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = rdata;
    mem_raddr      = idx;
    q_pop          = 1'b0;

    if (shf == SHF_ON) begin
      // Shift down: rdata holds entry idx+1, move it into idx
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = rdata;
      mem_raddr = idx + AW'(2);
      if (hrel && (idx == '0)) begin
        holder_next  = rdata.client_id;
        gvalid_next  = 1'b1;
        gclient_next = rdata.client_id;
      end
      if (idx_p1_last) begin
        count_next = cnt_m1;
        shf_next   = SHF_OFF;
        state_next = S_DONE;
      end else begin
        idx_next = idx + AW'(1);
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            q_pop        = 1'b1;
            op_next      = q_status.head;
            hrel_next    = 1'b0;
            gvalid_next  = 1'b0;
            gclient_next = '0;
            ovf_next     = 1'b0;
            unk_next     = 1'b0;
            state_next   = S_DONE;
            case (q_status.head.kind)
              tola_pkg::OP_REQUEST: begin
                if (count == CW'(MAX_CLIENTS)) begin
                  ovf_next = 1'b1;
                end else if (count == '0) begin
                  // Empty queue: the requester takes the lock at once
                  mem_we       = 1'b1;
                  mem_waddr    = '0;
                  mem_wdata    = head_entry;
                  count_next   = CW'(1);
                  locked_next  = 1'b1;
                  holder_next  = q_status.head.client_id;
                  gvalid_next  = 1'b1;
                  gclient_next = q_status.head.client_id;
                end else if (count == CW'(1)) begin
                  mem_we     = 1'b1;
                  mem_waddr  = AW'(1);
                  mem_wdata  = head_entry;
                  count_next = count + CW'(1);
                end else begin
                  idx_next   = AW'(cnt_m1);
                  state_next = S_INS_RD;
                end
              end
              tola_pkg::OP_RELEASE: begin
                if (locked && (holder == q_status.head.client_id)) begin
                  if (count == CW'(1)) begin
                    count_next  = '0;
                    locked_next = 1'b0;
                    holder_next = '0;
                  end else begin
                    idx_next   = '0;
                    hrel_next  = 1'b1;
                    state_next = S_SHF_RD;
                  end
                end else if (locked && (count > CW'(1))) begin
                  idx_next   = AW'(1);
                  state_next = S_SRCH_RD;
                end else begin
                  unk_next = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_INS_RD: begin
          mem_raddr  = idx;
          state_next = S_INS;
        end

        // Walk down from the tail, moving later stamps up one slot
        S_INS: begin
          mem_raddr = idx - AW'(1);
          if (rdata.stamp > op.stamp) begin
            mem_we    = 1'b1;
            mem_waddr = idx + AW'(1);
            mem_wdata = rdata;
            if (idx == AW'(1)) begin
              state_next = S_INS_PUT;
            end else begin
              idx_next = idx - AW'(1);
            end
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = idx + AW'(1);
            mem_wdata  = new_entry;
            count_next = count + CW'(1);
            state_next = S_DONE;
          end
        end

        S_INS_PUT: begin
          mem_we     = 1'b1;
          mem_waddr  = idx;
          mem_wdata  = new_entry;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end

        S_SRCH_RD: begin
          mem_raddr  = idx;
          state_next = S_SRCH;
        end

        // Look for the first waiting entry of this client
        S_SRCH: begin
          mem_raddr = idx + AW'(1);
          if (rdata.client_id == op.client_id) begin
            if (idx_last) begin
              count_next = cnt_m1;
              state_next = S_DONE;
            end else begin
              shf_next = SHF_ON;
            end
          end else if (idx_last) begin
            unk_next   = 1'b1;
            state_next = S_DONE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end

        S_SHF_RD: begin
          mem_raddr = idx + AW'(1);
          shf_next  = SHF_ON;
        end

        // Publish the result once the output register is free
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid_next                = 1'b1;
            res_data_next.grant_valid     = gvalid;
            res_data_next.grant_client    = gclient;
            res_data_next.locked          = locked;
            res_data_next.holder          = locked ? holder : '0;
            res_data_next.queue_count     = cnt_wide[tola_pkg::QCNT_W-1:0];
            res_data_next.overflow        = ovf;
            res_data_next.unknown_release = unk;
            state_next                    = S_IDLE;
          end
        end

        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      shf       <= SHF_OFF;
      count     <= '0;
      locked    <= 1'b0;
      holder    <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      shf       <= shf_next;
      count     <= count_next;
      locked    <= locked_next;
      holder    <= holder_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    idx      <= idx_next;
    hrel     <= hrel_next;
    gvalid   <= gvalid_next;
    gclient  <= gclient_next;
    ovf      <= ovf_next;
    unk      <= unk_next;
    res_data <= res_data_next;
  end

  assign res.valid           = res_valid;
  assign res.grant_valid     = res_data.grant_valid;
  assign res.grant_client    = res_data.grant_client;
  assign res.locked          = res_data.locked;
  assign res.holder          = res_data.holder;
  assign res.queue_count     = res_data.queue_count;
  assign res.overflow        = res_data.overflow;
  assign res.unknown_release = res_data.unknown_release;

endmodule

`default_nettype wire
